@@ rtl/strided_tensor_reshape_walker_unit_macros.svh @@
// assertion macros shared by the strided tensor reshape walker rtl
// expects signals named clock and reset (synchronous, active high) in the using module
`ifndef STRIDED_TENSOR_RESHAPE_WALKER_UNIT_MACROS_SVH
`define STRIDED_TENSOR_RESHAPE_WALKER_UNIT_MACROS_SVH

// same-cycle implication, off during reset
`define STRW_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off during reset
`define STRW_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/strw_pkg.sv @@
// shared types and constants of the strided tensor reshape walker
// no dependencies; used by strw_div and strided_tensor_reshape_walker_unit
package strw_pkg;

   // default widths of one dimension size and one byte stride
   localparam int DIM_BITS_DEF    = 13;
   localparam int STRIDE_BITS_DEF = 26;

   // fixed field widths
   localparam int POS_W  = 32;
   localparam int OFS_W  = 41;
   localparam int REG_W  = 52;
   localparam int DATA_W = 64;
   localparam int ADDR_W = 6;

   // register file
   localparam int REG_NUM   = 6;
   localparam int REG_IDX_W = 3;
   localparam logic [REG_IDX_W-1:0] REG_SRC_DIMS   = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_DST_DIMS   = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_SRC_STR_LO = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_SRC_STR_HI = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_DST_STR_LO = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_DST_STR_HI = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_COUNT      = 3'd6;

   // sequencer step counter and its step codes
   localparam int CNT_W = 4;
   localparam logic [CNT_W-1:0] PRD_SRC_P1  = 4'd0;
   localparam logic [CNT_W-1:0] PRD_SRC_P2  = 4'd1;
   localparam logic [CNT_W-1:0] PRD_DST_P1  = 4'd2;
   localparam logic [CNT_W-1:0] PRD_DST_P2  = 4'd3;
   localparam logic [CNT_W-1:0] PRD_TOTAL   = 4'd4;
   localparam logic [CNT_W-1:0] DIV_SRC_HI  = 4'd0;
   localparam logic [CNT_W-1:0] DIV_SRC_MID = 4'd1;
   localparam logic [CNT_W-1:0] DIV_SRC_LO  = 4'd2;
   localparam logic [CNT_W-1:0] DIV_DST_HI  = 4'd3;
   localparam logic [CNT_W-1:0] DIV_DST_MID = 4'd4;
   localparam logic [CNT_W-1:0] DIV_DST_LO  = 4'd5;
   localparam logic [CNT_W-1:0] OFS_LAST    = 4'd8;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PROD,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_WALK,
      ST_OFS,
      ST_EMIT
   } state_type;

   // divider status toward the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_sts_type;

endpackage

@@ rtl/strw_div.sv @@
// iterative restoring divider, one quotient bit per cycle
// depends on strw_pkg and strided_tensor_reshape_walker_unit_macros.svh
`include "strided_tensor_reshape_walker_unit_macros.svh"

module strw_div #(
   parameter int DVD_W = strw_pkg::POS_W,
   parameter int DVS_W = 3 * strw_pkg::DIM_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DVD_W-1:0]     dividend,
   input  logic [DVS_W-1:0]     divisor,
   output logic [DVD_W-1:0]     quotient,
   output logic [DVD_W-1:0]     remainder,
   output strw_pkg::div_sts_type sts
);

   localparam int CMP_W = (DVD_W + 1 > DVS_W) ? DVD_W + 1 : DVS_W;
   localparam int CNT_W = $clog2(DVD_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DVD_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;

   logic [DVD_W:0]   trial;
   logic [CMP_W-1:0] trial_ext;
   logic [CMP_W-1:0] dvs_ext;
   logic [CMP_W-1:0] diff;
   logic             take;

   // partial remainder never exceeds the dividend bits shifted in so far
   assign trial     = {rem_ff, quo_ff[DVD_W-1]};
   assign trial_ext = CMP_W'(trial);
   assign dvs_ext   = CMP_W'(dvs_ff);
   assign diff      = trial_ext - dvs_ext;
   assign take      = (trial_ext >= dvs_ext);

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (busy_ff) begin
         rem_in = take ? diff[DVD_W-1:0] : trial[DVD_W-1:0];
         quo_in = {quo_ff[DVD_W-2:0], take};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = CNT_W'(DVD_W);
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign quotient  = quo_ff;
   assign remainder = rem_ff;
   assign sts.busy  = busy_ff;
   assign sts.done  = done_ff;

   `STRW_ASSERT_NEXT(a_div_goes_busy, start && !busy_ff, busy_ff, "divider did not start")
   `STRW_ASSERT_NOW(a_div_rem_below, done_ff, (dvs_ff == '0) || (CMP_W'(rem_ff) < dvs_ext), "remainder not below divisor")
   `STRW_ASSERT_NEXT(a_div_done_pulse, done_ff, !done_ff, "done held longer than one cycle")

endmodule

@@ rtl/strided_tensor_reshape_walker_unit.sv @@
// top level of the strided tensor reshape walker: csr file, sequencer, shared multiplier
// depends on strw_pkg, strw_div and strided_tensor_reshape_walker_unit_macros.svh
//
// usage
//   req channel (req_valid / req_stall): one beat carries restart and start_index.
//   restart = 1 splits start_index into a source and a destination index tuple;
//   restart = 0 steps both tuples one row-major element forward while not past the end.
//   rsp channel (rsp_valid / rsp_stall): one beat per request with both byte
//   offsets, the last-element flag and the past-the-end flag.
//   csr port: apb-style, 64-bit data, register i at byte address 8*i, pready tied high.
//   the user must write registers only while idle; the block does not enforce it.
// sequence
//   a step beat goes through the walk state, the offset pass on the shared
//   multiplier (eight partial products plus the last accumulate) and the emit
//   state that loads the output register.
//   a restart beat first forms the size products on the shared multiplier,
//   then runs six divisions on the divider, each producing 32 quotient bits,
//   one per cycle, then the offset pass.
//   req_stall is high while a beat is being worked on.
// reset
//   synchronous reset clears the registers, both index tuples, the position and
//   the element count, so every step before the first restart is past the end.
// output stall
//   a finished beat waits in the output register; the next request is taken
//   meanwhile and its result is held back until the output register frees up.

`include "strided_tensor_reshape_walker_unit_macros.svh"

module strided_tensor_reshape_walker_unit #(
   parameter int DIM_BITS    = strw_pkg::DIM_BITS_DEF,
   parameter int STRIDE_BITS = strw_pkg::STRIDE_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_restart,
   input  logic [strw_pkg::POS_W-1:0]  req_start_index,
   // result channel
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [strw_pkg::OFS_W-1:0]  rsp_source_offset,
   output logic [strw_pkg::OFS_W-1:0]  rsp_dest_offset,
   output logic                        rsp_final_element,
   output logic                        rsp_past_end,
   // configuration port
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [strw_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [strw_pkg::DATA_W-1:0] csr_pwdata,
   output logic [strw_pkg::DATA_W-1:0] csr_prdata,
   output logic                        csr_pready
);

   // multiplier operand a carries sizes, size products and strides, operand b one size or index
   localparam int A_W   = (3 * DIM_BITS > STRIDE_BITS) ? 3 * DIM_BITS : STRIDE_BITS;
   localparam int P_W   = A_W + DIM_BITS;
   localparam int TOT_W = 4 * DIM_BITS;
   localparam int DVS_W = 3 * DIM_BITS;
   localparam int LIM_W = ((strw_pkg::POS_W > TOT_W) ? strw_pkg::POS_W : TOT_W) + 1;

   typedef logic [3:0][DIM_BITS-1:0]    tuple_type;
   typedef logic [3:0][STRIDE_BITS-1:0] stride_type;

   // one row-major step of an index tuple; a tuple over a zero size stays at zero
   function automatic tuple_type walk_tuple(input tuple_type idx, input tuple_type dim);
      tuple_type nxt;
      logic      carry;
      logic      zero;
      nxt   = idx;
      carry = 1'b1;
      zero  = 1'b0;
      for (int k = 0; k < 4; k++) begin
         if (dim[k] == '0) begin
            zero = 1'b1;
         end
      end
      for (int k = 0; k < 3; k++) begin
         if (carry) begin
            // an index left beyond its size by a register change wraps too
            if (({1'b0, idx[k]} + 1'b1) >= {1'b0, dim[k]}) begin
               nxt[k] = '0;
            end else begin
               nxt[k] = idx[k] + DIM_BITS'(1);
               carry  = 1'b0;
            end
         end
      end
      // outermost index wraps within its width
      if (carry) begin
         nxt[3] = idx[3] + DIM_BITS'(1);
      end
      if (zero) begin
         nxt = '0;
      end
      return nxt;
   endfunction

   // control state
   strw_pkg::state_type               state_ff, state_in;
   logic [strw_pkg::CNT_W-1:0]        cnt_ff, cnt_in;
   logic [strw_pkg::REG_W-1:0]        cfg_ff [strw_pkg::REG_NUM];
   logic [strw_pkg::REG_W-1:0]        cfg_in [strw_pkg::REG_NUM];
   tuple_type                         sidx_ff, sidx_in;
   tuple_type                         didx_ff, didx_in;
   logic [strw_pkg::POS_W-1:0]        pos_ff, pos_in;
   logic [TOT_W-1:0]                  total_ff, total_in;
   logic                              rsp_valid_ff, rsp_valid_in;

   // payload state
   logic [2*DIM_BITS-1:0]             p1s_ff, p1s_in;
   logic [3*DIM_BITS-1:0]             p2s_ff, p2s_in;
   logic [2*DIM_BITS-1:0]             p1d_ff, p1d_in;
   logic [3*DIM_BITS-1:0]             p2d_ff, p2d_in;
   logic [strw_pkg::POS_W-1:0]        rem_ff, rem_in;
   logic [P_W-1:0]                    prod_ff, prod_in;
   logic [strw_pkg::OFS_W-1:0]        sacc_ff, sacc_in;
   logic [strw_pkg::OFS_W-1:0]        dacc_ff, dacc_in;
   logic [strw_pkg::OFS_W-1:0]        rsp_src_ff, rsp_src_in;
   logic [strw_pkg::OFS_W-1:0]        rsp_dst_ff, rsp_dst_in;
   logic                              rsp_final_ff, rsp_final_in;
   logic                              rsp_past_ff, rsp_past_in;

   // combinational helpers
   logic                              in_accept;
   logic                              csr_write;
   logic [strw_pkg::REG_IDX_W-1:0]    csr_idx;
   tuple_type                         sdim, ddim;
   stride_type                        sstr, dstr;
   logic                              src_zero, dst_zero;
   logic                              past, final_hit, can_advance, can_load;
   logic [A_W-1:0]                    mul_a;
   logic [DIM_BITS-1:0]               mul_b;
   logic [P_W-1:0]                    mul_p;
   logic [1:0]                        ofs_k;
   logic [strw_pkg::CNT_W-1:0]        acc_step;

   // divider hookup
   logic                              div_start;
   logic [strw_pkg::POS_W-1:0]        div_dividend;
   logic [DVS_W-1:0]                  div_divisor;
   logic [strw_pkg::POS_W-1:0]        div_quo;
   logic [strw_pkg::POS_W-1:0]        div_rem;
   strw_pkg::div_sts_type             div_sts;

   strw_div #(
      .DVD_W (strw_pkg::POS_W),
      .DVS_W (DVS_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .quotient  (div_quo),
      .remainder (div_rem),
      .sts       (div_sts)
   );

   // handshakes
   assign req_stall  = (state_ff != strw_pkg::ST_IDLE);
   assign in_accept  = req_valid && !req_stall;
   assign can_load   = !rsp_valid_ff || !rsp_stall;
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_paddr[strw_pkg::ADDR_W-1:3];

   // register read back, unused addresses read as zero
   always_comb begin
      csr_prdata = '0;
      if (csr_idx < strw_pkg::REG_COUNT) begin
         csr_prdata = strw_pkg::DATA_W'(cfg_ff[csr_idx]);
      end
   end

   // register fields, live: sizes and strides act at once
   assign sdim = tuple_type'(cfg_ff[strw_pkg::REG_SRC_DIMS][TOT_W-1:0]);
   assign ddim = tuple_type'(cfg_ff[strw_pkg::REG_DST_DIMS][TOT_W-1:0]);
   assign sstr = {cfg_ff[strw_pkg::REG_SRC_STR_HI][2*STRIDE_BITS-1:0],
                  cfg_ff[strw_pkg::REG_SRC_STR_LO][2*STRIDE_BITS-1:0]};
   assign dstr = {cfg_ff[strw_pkg::REG_DST_STR_HI][2*STRIDE_BITS-1:0],
                  cfg_ff[strw_pkg::REG_DST_STR_LO][2*STRIDE_BITS-1:0]};
   assign src_zero = (sdim[0] == '0) || (sdim[1] == '0) || (sdim[2] == '0) || (sdim[3] == '0);
   assign dst_zero = (ddim[0] == '0) || (ddim[1] == '0) || (ddim[2] == '0) || (ddim[3] == '0);

   // end of tensor judged by the destination count latched at restart
   assign past        = (LIM_W'(pos_ff) >= LIM_W'(total_ff));
   assign final_hit   = !past && ((LIM_W'(pos_ff) + LIM_W'(1)) == LIM_W'(total_ff));
   assign can_advance = !past && (pos_ff != '1);

   // the shared multiplier
   assign mul_p = P_W'(mul_a) * P_W'(mul_b);

   // offset pass: steps 0..3 source, 4..7 destination, accumulate one step behind
   assign ofs_k    = cnt_ff[1:0];
   assign acc_step = cnt_ff - 1'b1;

   // divider operands follow the division step in cnt_ff
   always_comb begin
      div_dividend = rem_ff;
      div_divisor  = '0;
      unique case (cnt_ff)
         strw_pkg::DIV_SRC_HI: begin
            div_dividend = pos_ff;
            div_divisor  = p2s_ff;
         end
         strw_pkg::DIV_SRC_MID: div_divisor = DVS_W'(p1s_ff);
         strw_pkg::DIV_SRC_LO:  div_divisor = DVS_W'(sdim[0]);
         strw_pkg::DIV_DST_HI: begin
            div_dividend = pos_ff;
            div_divisor  = p2d_ff;
         end
         strw_pkg::DIV_DST_MID: div_divisor = DVS_W'(p1d_ff);
         strw_pkg::DIV_DST_LO:  div_divisor = DVS_W'(ddim[0]);
         default: div_divisor = '0;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         strw_pkg::ST_IDLE: begin
            if (in_accept) begin
               state_in = req_restart ? strw_pkg::ST_PROD : strw_pkg::ST_WALK;
            end
         end
         strw_pkg::ST_PROD: begin
            if (cnt_ff == strw_pkg::PRD_TOTAL) begin
               state_in = strw_pkg::ST_DIV_START;
            end
         end
         strw_pkg::ST_DIV_START: state_in = strw_pkg::ST_DIV_WAIT;
         strw_pkg::ST_DIV_WAIT: begin
            if (div_sts.done) begin
               state_in = (cnt_ff == strw_pkg::DIV_DST_LO) ? strw_pkg::ST_OFS
                                                           : strw_pkg::ST_DIV_START;
            end
         end
         strw_pkg::ST_WALK: state_in = strw_pkg::ST_OFS;
         strw_pkg::ST_OFS: begin
            if (cnt_ff == strw_pkg::OFS_LAST) begin
               state_in = strw_pkg::ST_EMIT;
            end
         end
         strw_pkg::ST_EMIT: begin
            if (can_load) begin
               state_in = strw_pkg::ST_IDLE;
            end
         end
         default: state_in = strw_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs of the sequencer
   always_comb begin
      cnt_in       = cnt_ff;
      cfg_in       = cfg_ff;
      sidx_in      = sidx_ff;
      didx_in      = didx_ff;
      pos_in       = pos_ff;
      total_in     = total_ff;
      p1s_in       = p1s_ff;
      p2s_in       = p2s_ff;
      p1d_in       = p1d_ff;
      p2d_in       = p2d_ff;
      rem_in       = rem_ff;
      prod_in      = prod_ff;
      sacc_in      = sacc_ff;
      dacc_in      = dacc_ff;
      rsp_src_in   = rsp_src_ff;
      rsp_dst_in   = rsp_dst_ff;
      rsp_final_in = rsp_final_ff;
      rsp_past_in  = rsp_past_ff;
      mul_a        = '0;
      mul_b        = '0;
      div_start    = 1'b0;

      // csr writes, addresses past the list are dropped
      if (csr_write && (csr_idx < strw_pkg::REG_COUNT)) begin
         cfg_in[csr_idx] = csr_pwdata[strw_pkg::REG_W-1:0];
      end

      unique case (state_ff)
         strw_pkg::ST_IDLE: begin
            if (in_accept) begin
               cnt_in  = '0;
               sacc_in = '0;
               dacc_in = '0;
               if (req_restart) begin
                  pos_in = req_start_index;
               end
            end
         end

         // size products: d0*d1, then times d2, for both tensors, then the element count
         strw_pkg::ST_PROD: begin
            cnt_in = (cnt_ff == strw_pkg::PRD_TOTAL) ? '0 : cnt_ff + 1'b1;
            unique case (cnt_ff)
               strw_pkg::PRD_SRC_P1: begin
                  mul_a  = A_W'(sdim[0]);
                  mul_b  = sdim[1];
                  p1s_in = mul_p[2*DIM_BITS-1:0];
               end
               strw_pkg::PRD_SRC_P2: begin
                  mul_a  = A_W'(p1s_ff);
                  mul_b  = sdim[2];
                  p2s_in = mul_p[3*DIM_BITS-1:0];
               end
               strw_pkg::PRD_DST_P1: begin
                  mul_a  = A_W'(ddim[0]);
                  mul_b  = ddim[1];
                  p1d_in = mul_p[2*DIM_BITS-1:0];
               end
               strw_pkg::PRD_DST_P2: begin
                  mul_a  = A_W'(p1d_ff);
                  mul_b  = ddim[2];
                  p2d_in = mul_p[3*DIM_BITS-1:0];
               end
               strw_pkg::PRD_TOTAL: begin
                  mul_a    = A_W'(p2d_ff);
                  mul_b    = ddim[3];
                  total_in = mul_p[TOT_W-1:0];
               end
               default: mul_a = '0;
            endcase
         end

         strw_pkg::ST_DIV_START: div_start = 1'b1;

         // split: outer quotient, then remainder by inner products
         strw_pkg::ST_DIV_WAIT: begin
            if (div_sts.done) begin
               cnt_in = (cnt_ff == strw_pkg::DIV_DST_LO) ? '0 : cnt_ff + 1'b1;
               unique case (cnt_ff)
                  strw_pkg::DIV_SRC_HI: begin
                     sidx_in[3] = div_quo[DIM_BITS-1:0];
                     rem_in     = div_rem;
                  end
                  strw_pkg::DIV_SRC_MID: begin
                     sidx_in[2] = div_quo[DIM_BITS-1:0];
                     rem_in     = div_rem;
                  end
                  strw_pkg::DIV_SRC_LO: begin
                     if (src_zero) begin
                        sidx_in = '0;
                     end else begin
                        sidx_in[1] = div_quo[DIM_BITS-1:0];
                        sidx_in[0] = div_rem[DIM_BITS-1:0];
                     end
                  end
                  strw_pkg::DIV_DST_HI: begin
                     didx_in[3] = div_quo[DIM_BITS-1:0];
                     rem_in     = div_rem;
                  end
                  strw_pkg::DIV_DST_MID: begin
                     didx_in[2] = div_quo[DIM_BITS-1:0];
                     rem_in     = div_rem;
                  end
                  strw_pkg::DIV_DST_LO: begin
                     if (dst_zero) begin
                        didx_in = '0;
                     end else begin
                        didx_in[1] = div_quo[DIM_BITS-1:0];
                        didx_in[0] = div_rem[DIM_BITS-1:0];
                     end
                  end
                  default: rem_in = rem_ff;
               endcase
            end
         end

         // step both tuples; past the end or at the top position nothing moves
         strw_pkg::ST_WALK: begin
            cnt_in = '0;
            if (can_advance) begin
               pos_in  = pos_ff + 1'b1;
               sidx_in = walk_tuple(sidx_ff, sdim);
               didx_in = walk_tuple(didx_ff, ddim);
            end
         end

         // index times stride into prod_ff, summed into the offset in the next cycle
         strw_pkg::ST_OFS: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff[2]) begin
               mul_a = A_W'(dstr[ofs_k]);
               mul_b = didx_ff[ofs_k];
            end else begin
               mul_a = A_W'(sstr[ofs_k]);
               mul_b = sidx_ff[ofs_k];
            end
            prod_in = mul_p;
            if (cnt_ff != '0) begin
               if (acc_step[2]) begin
                  dacc_in = dacc_ff + strw_pkg::OFS_W'(prod_ff);
               end else begin
                  sacc_in = sacc_ff + strw_pkg::OFS_W'(prod_ff);
               end
            end
         end

         strw_pkg::ST_EMIT: begin
            if (can_load) begin
               rsp_src_in   = past ? '0 : sacc_ff;
               rsp_dst_in   = past ? '0 : dacc_ff;
               rsp_final_in = final_hit;
               rsp_past_in  = past;
            end
         end

         default: cnt_in = '0;
      endcase

      // output register: cleared on a taken beat, loaded when the result is done
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if ((state_ff == strw_pkg::ST_EMIT) && can_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= strw_pkg::ST_IDLE;
         cnt_ff       <= '0;
         for (int i = 0; i < strw_pkg::REG_NUM; i++) begin
            cfg_ff[i] <= '0;
         end
         sidx_ff      <= '0;
         didx_ff      <= '0;
         pos_ff       <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         cfg_ff       <= cfg_in;
         sidx_ff      <= sidx_in;
         didx_ff      <= didx_in;
         pos_ff       <= pos_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p1s_ff       <= p1s_in;
      p2s_ff       <= p2s_in;
      p1d_ff       <= p1d_in;
      p2d_ff       <= p2d_in;
      rem_ff       <= rem_in;
      prod_ff      <= prod_in;
      sacc_ff      <= sacc_in;
      dacc_ff      <= dacc_in;
      rsp_src_ff   <= rsp_src_in;
      rsp_dst_ff   <= rsp_dst_in;
      rsp_final_ff <= rsp_final_in;
      rsp_past_ff  <= rsp_past_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_source_offset = rsp_src_ff;
   assign rsp_dest_offset   = rsp_dst_ff;
   assign rsp_final_element = rsp_final_ff;
   assign rsp_past_end      = rsp_past_ff;

   `STRW_ASSERT_NEXT(a_busy_after_accept, in_accept, req_stall, "request taken but block not busy")
   `STRW_ASSERT_NOW(a_past_end_zero, rsp_valid_ff && rsp_past_ff, (rsp_src_ff == '0) && (rsp_dst_ff == '0) && !rsp_final_ff, "past-end beat with offsets or final flag")
   `STRW_ASSERT_NOW(a_div_start_free, div_start, !div_sts.busy, "divider started while busy")
   `STRW_ASSERT_NOW(a_ofs_count, state_ff == strw_pkg::ST_OFS, cnt_ff <= strw_pkg::OFS_LAST, "offset pass overran")

endmodule

@@ verif/testbench.sv @@
// self-checking bench for strided_tensor_reshape_walker_unit: directed walks, then random layouts
// depends on strw_pkg and the walker rtl; a scoreboard class predicts offsets and flags
`timescale 1ns / 100ps

module testbench;
   import strw_pkg::*;

   // a step may advance at most to this position, then repeats it
   localparam logic [63:0] LAST_POSITION = 64'hFFFF_FFFF;

   // one index tuple, dimension 0 in the low bits
   typedef logic [3:0][DIM_BITS_DEF-1:0] index_tuple_type;

   typedef struct packed {
      logic [OFS_W-1:0] source_offset;
      logic [OFS_W-1:0] dest_offset;
      logic             final_element;
      logic             past_end;
   } walk_result_type;

   typedef struct packed {
      logic             restart;
      logic [POS_W-1:0] start_index;
   } walk_request_type;

   // keeps its own copy of the registers and of the walk position, works out
   // the offsets for every accepted beat and checks results in order
   class reshape_walk_scoreboard;
      logic [REG_W-1:0] csr_image [REG_NUM];
      index_tuple_type  src_idx;
      index_tuple_type  dst_idx;
      logic [63:0]      position;
      logic [63:0]      element_count;
      walk_result_type  expected_offsets [$];
      int unsigned      failures;

      function void reset_state();
         int r;
         for (r = 0; r < REG_NUM; r++) csr_image[r] = '0;
         src_idx = '0;
         dst_idx = '0;
         position = '0;
         element_count = '0;
         expected_offsets.delete();
         failures = 0;
      endfunction

      function void note_csr_write(logic [REG_IDX_W-1:0] idx, logic [REG_W-1:0] value);
         csr_image[idx] = value;
      endfunction

      function logic [DIM_BITS_DEF-1:0] dim_at(logic [REG_IDX_W-1:0] r, int k);
         return csr_image[r][k * DIM_BITS_DEF +: DIM_BITS_DEF];
      endfunction

      function logic [STRIDE_BITS_DEF-1:0] stride_at(logic [REG_IDX_W-1:0] base, int k);
         return csr_image[base + k / 2][(k % 2) * STRIDE_BITS_DEF +: STRIDE_BITS_DEF];
      endfunction

      function bit has_zero_dim(logic [REG_IDX_W-1:0] r);
         int k;
         for (k = 0; k < 4; k++)
            if (dim_at(r, k) == 0) return 1'b1;
         return 1'b0;
      endfunction

      // product of the destination sizes as the block latches it at a restart
      function logic [63:0] dest_element_count();
         logic [63:0] prod;
         prod = 64'(dim_at(REG_DST_DIMS, 0)) * 64'(dim_at(REG_DST_DIMS, 1)) *
                64'(dim_at(REG_DST_DIMS, 2)) * 64'(dim_at(REG_DST_DIMS, 3));
         return 64'(prod[REG_W-1:0]);
      endfunction

      // flat index to tuple; the outermost index keeps only its low bits
      function index_tuple_type split_flat(logic [63:0] flat, logic [REG_IDX_W-1:0] r);
         index_tuple_type t;
         logic [63:0]     d0, p1, p2, rest;
         t = '0;
         if (has_zero_dim(r)) return t;
         d0 = 64'(dim_at(r, 0));
         p1 = d0 * 64'(dim_at(r, 1));
         p2 = p1 * 64'(dim_at(r, 2));
         t[3] = DIM_BITS_DEF'(flat / p2);
         rest = flat % p2;
         t[2] = DIM_BITS_DEF'(rest / p1);
         rest = rest % p1;
         t[1] = DIM_BITS_DEF'(rest / d0);
         t[0] = DIM_BITS_DEF'(rest % d0);
         return t;
      endfunction

      // one row-major step; an index at or beyond its size wraps to zero and carries
      function index_tuple_type walk_one(index_tuple_type t, logic [REG_IDX_W-1:0] r);
         logic carry;
         int   k;
         if (has_zero_dim(r)) return '0;
         carry = 1'b1;
         for (k = 0; k < 3; k++) begin
            if (carry) begin
               if (64'(t[k]) + 64'd1 >= 64'(dim_at(r, k))) begin
                  t[k] = '0;
               end else begin
                  t[k] = t[k] + 1'b1;
                  carry = 1'b0;
               end
            end
         end
         if (carry) t[3] = t[3] + 1'b1;
         return t;
      endfunction

      function logic [OFS_W-1:0] offset_sum(index_tuple_type t, logic [REG_IDX_W-1:0] base);
         logic [63:0] total;
         int          k;
         total = '0;
         for (k = 0; k < 4; k++) total += 64'(t[k]) * 64'(stride_at(base, k));
         return OFS_W'(total);
      endfunction

      function void note_request(logic restart, logic [POS_W-1:0] start_index);
         walk_result_type want;
         logic            past;
         if (restart) begin
            position = 64'(start_index);
            element_count = dest_element_count();
            src_idx = split_flat(position, REG_SRC_DIMS);
            dst_idx = split_flat(position, REG_DST_DIMS);
         end else if (position < element_count && position < LAST_POSITION) begin
            position++;
            src_idx = walk_one(src_idx, REG_SRC_DIMS);
            dst_idx = walk_one(dst_idx, REG_DST_DIMS);
         end
         past = (position >= element_count);
         want.source_offset = past ? '0 : offset_sum(src_idx, REG_SRC_STR_LO);
         want.dest_offset = past ? '0 : offset_sum(dst_idx, REG_DST_STR_LO);
         want.final_element = !past && (position + 64'd1 == element_count);
         want.past_end = past;
         expected_offsets.push_back(want);
      endfunction

      function void compare_field(string field_name, logic [63:0] want, logic [63:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field_name, want, got);
            failures++;
         end
      endfunction

      function void check_offsets(walk_result_type got);
         walk_result_type want;
         if (expected_offsets.size() == 0) begin
            $display("%0t: result beat with nothing expected, actual %h %h %b %b", $time,
                     got.source_offset, got.dest_offset, got.final_element, got.past_end);
            failures++;
            return;
         end
         want = expected_offsets.pop_front();
         compare_field("source_offset", want.source_offset, got.source_offset);
         compare_field("dest_offset", want.dest_offset, got.dest_offset);
         compare_field("final_element", want.final_element, got.final_element);
         compare_field("past_end", want.past_end, got.past_end);
      endfunction

      function int outstanding();
         return expected_offsets.size();
      endfunction

      function void report_leftovers();
         if (expected_offsets.size() != 0) begin
            $display("%0t: %0d result beats never arrived", $time, expected_offsets.size());
            failures++;
         end
      endfunction
   endclass

   logic                clock;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic                req_restart = 1'b0;
   logic [POS_W-1:0]    req_start_index = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [OFS_W-1:0]    rsp_source_offset;
   logic [OFS_W-1:0]    rsp_dest_offset;
   logic                rsp_final_element;
   logic                rsp_past_end;
   logic                csr_psel = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite = 1'b0;
   logic [ADDR_W-1:0]   csr_paddr = '0;
   logic [DATA_W-1:0]   csr_pwdata = '0;
   logic [DATA_W-1:0]   csr_prdata;
   logic                csr_pready;

   reshape_walk_scoreboard walk_sb = new;
   walk_request_type       request_plan [$];
   // set by the stimulus side, picked up and counted down by the result side
   bit                     long_hold_armed = 1'b0;

   strided_tensor_reshape_walker_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_restart       (req_restart),
      .req_start_index   (req_start_index),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_source_offset (rsp_source_offset),
      .rsp_dest_offset   (rsp_dest_offset),
      .rsp_final_element (rsp_final_element),
      .rsp_past_end      (rsp_past_end),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // hard stop in case a handshake never completes
   initial begin
      #12_000_000;
      $display("testbench NOT OK");
      $finish;
   end

   function automatic logic [REG_W-1:0] pack_dims(int d0, int d1, int d2, int d3);
      return {DIM_BITS_DEF'(d3), DIM_BITS_DEF'(d2), DIM_BITS_DEF'(d1), DIM_BITS_DEF'(d0)};
   endfunction

   function automatic logic [REG_W-1:0] pack_strides(int lo, int hi);
      return {STRIDE_BITS_DEF'(hi), STRIDE_BITS_DEF'(lo)};
   endfunction

   // size styles: tiny, moderate, full range, one zero size, each 1 or the maximum
   function automatic logic [REG_W-1:0] random_dims(int unsigned style);
      logic [REG_W-1:0]        packed_dims;
      logic [DIM_BITS_DEF-1:0] d;
      int                      k, zero_at;
      packed_dims = '0;
      zero_at = $urandom_range(0, 3);
      for (k = 0; k < 4; k++) begin
         case (style)
            0:       d = $urandom_range(1, 6);
            1:       d = $urandom_range(1, 40);
            2:       d = $urandom_range(0, 8191);
            3:       d = (k == zero_at) ? '0 : DIM_BITS_DEF'($urandom_range(1, 5));
            default: d = $urandom_range(0, 1) ? '1 : DIM_BITS_DEF'(1);
         endcase
         packed_dims[k * DIM_BITS_DEF +: DIM_BITS_DEF] = d;
      end
      return packed_dims;
   endfunction

   // stride styles: small element pitches, full random, zero or maximum
   function automatic logic [REG_W-1:0] random_strides();
      logic [REG_W-1:0] value;
      case ($urandom_range(0, 2))
         0:       value = pack_strides($urandom_range(0, 64), $urandom_range(0, 64));
         1:       value = {$urandom(), $urandom()};
         default: value = {$urandom_range(0, 1) ? {STRIDE_BITS_DEF{1'b1}} : 26'd0,
                           $urandom_range(0, 1) ? {STRIDE_BITS_DEF{1'b1}} : 26'd0};
      endcase
      return value;
   endfunction

   // apb write: setup cycle, access cycle, register takes the value at the pready edge
   task automatic write_csr(logic [REG_IDX_W-1:0] idx, logic [REG_W-1:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 3'b000};
      csr_pwdata <= DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      walk_sb.note_csr_write(idx, value);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_layout(logic [REG_W-1:0] src_dims, logic [REG_W-1:0] dst_dims,
                             logic [REG_W-1:0] src_lo, logic [REG_W-1:0] src_hi,
                             logic [REG_W-1:0] dst_lo, logic [REG_W-1:0] dst_hi);
      write_csr(REG_SRC_DIMS, src_dims);
      write_csr(REG_DST_DIMS, dst_dims);
      write_csr(REG_SRC_STR_LO, src_lo);
      write_csr(REG_SRC_STR_HI, src_hi);
      write_csr(REG_DST_STR_LO, dst_lo);
      write_csr(REG_DST_STR_HI, dst_hi);
   endtask

   // random layout; often the destination is the source shape reversed,
   // which keeps the element counts equal as in a plain reshape
   task automatic pick_layout();
      logic [REG_W-1:0] src_dims, dst_dims;
      src_dims = random_dims($urandom_range(0, 4));
      if ($urandom_range(0, 1))
         dst_dims = {src_dims[12:0], src_dims[25:13], src_dims[38:26], src_dims[51:39]};
      else
         dst_dims = random_dims($urandom_range(0, 4));
      set_layout(src_dims, dst_dims, random_strides(), random_strides(),
                 random_strides(), random_strides());
   endtask

   task automatic add_request(logic restart, logic [POS_W-1:0] start_index);
      walk_request_type beat;
      beat.restart = restart;
      beat.start_index = start_index;
      request_plan.push_back(beat);
   endtask

   // mostly a restart followed by a run of steps; some runs skip the restart
   // and keep walking from wherever the last one left off
   task automatic queue_walks(int unsigned beats, logic [63:0] count);
      int unsigned      made, run, k;
      logic [POS_W-1:0] start;
      made = 0;
      while (made < beats) begin
         if ($urandom_range(0, 9) != 0) begin
            case ($urandom_range(0, 9))
               0, 1:    start = $urandom();
               2, 3, 4: start = (count == 0) ? POS_W'($urandom_range(0, 8))
                                             : POS_W'(64'($urandom()) % count);
               default: begin
                  // land close to the last element so the run walks off the end
                  if (count == 0) start = $urandom_range(0, 3);
                  else if (count > LAST_POSITION) start = 32'hFFFF_FFFF - $urandom_range(0, 20);
                  else if (count <= 24) start = $urandom_range(0, 32'(count) - 1);
                  else start = POS_W'(count - 64'($urandom_range(1, 24)));
               end
            endcase
            add_request(1'b1, start);
            made++;
         end
         run = $urandom_range(3, 30);
         for (k = 0; k < run; k++) add_request(1'b0, $urandom());
         made += run;
      end
   endtask

   // request side: bursts of back-to-back beats, sometimes separated by random gaps
   task automatic push_requests();
      walk_request_type beat;
      int unsigned      burst_left;
      burst_left = 0;
      while (request_plan.size() > 0) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 2) == 0) begin
               req_valid <= 1'b0;
               repeat ($urandom_range(1, 30)) @(posedge clock);
            end
         end
         beat = request_plan.pop_front();
         req_valid <= 1'b1;
         req_restart <= beat.restart;
         req_start_index <= beat.start_index;
         @(posedge clock);
         while (req_stall) @(posedge clock);
         walk_sb.note_request(beat.restart, beat.start_index);
         burst_left--;
      end
      req_valid <= 1'b0;
   endtask

   // bounded wait until every expected result beat is back
   task automatic wait_for_results(int unsigned limit);
      int unsigned waited;
      waited = 0;
      while (walk_sb.outstanding() != 0 && waited < limit) begin
         @(posedge clock);
         waited++;
      end
      repeat (16) @(posedge clock);
   endtask

   // result side: checks each accepted beat under a randomly chosen stall pattern
   initial begin : result_side
      int unsigned     hold_left, cycle_no, stall_mode;
      walk_result_type got;
      hold_left = 0;
      cycle_no = 0;
      stall_mode = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            got.source_offset = rsp_source_offset;
            got.dest_offset = rsp_dest_offset;
            got.final_element = rsp_final_element;
            got.past_end = rsp_past_end;
            walk_sb.check_offsets(got);
         end
         // long hold-off so the block fills up and pushes back on requests
         if (long_hold_armed) begin
            long_hold_armed = 1'b0;
            hold_left = 600;
         end
         if (cycle_no % 97 == 0) stall_mode = $urandom_range(0, 3);
         cycle_no++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            case (stall_mode)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= ($urandom_range(0, 7) == 0);
               2:       rsp_stall <= ($urandom_range(0, 1) == 0);
               default: rsp_stall <= ((cycle_no % 37) < 20);
            endcase
         end
      end
   end

   initial begin : stimulus
      int phase;
      walk_sb.reset_state();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // registers still at reset: element count is zero, everything is past the end
      add_request(1'b0, 32'hFFFF_FFFF);
      add_request(1'b1, 32'h0);
      push_requests();
      wait_for_results(20000);

      // 120 elements on both sides, different shapes
      set_layout(pack_dims(3, 4, 2, 5), pack_dims(5, 4, 3, 2),
                 pack_strides(4, 12), pack_strides(48, 96),
                 pack_strides(26'h3FF_FFFF, 7), pack_strides(1000, 26'h2AA_AAAA));
      add_request(1'b1, 32'd0);
      add_request(1'b0, 32'h0);
      add_request(1'b0, 32'hFFFF_FFFF);
      add_request(1'b0, 32'h5A5A_5A5A);
      add_request(1'b1, 32'd23);      // next step carries through three source dimensions
      add_request(1'b0, 32'h0);
      add_request(1'b1, 32'd118);     // one before the last element, then the last, then off the end
      add_request(1'b0, 32'h0);
      add_request(1'b0, 32'h0);
      add_request(1'b1, 32'd59);
      push_requests();
      wait_for_results(20000);

      // shrink the sizes under a live walk: indices beyond their size wrap,
      // the latched element count stays at 120
      write_csr(REG_SRC_DIMS, pack_dims(2, 2, 2, 8));
      write_csr(REG_DST_DIMS, pack_dims(2, 2, 2, 2));
      add_request(1'b0, 32'h0);
      add_request(1'b0, 32'h0);
      push_requests();
      wait_for_results(20000);

      // every register at its maximum: the position saturates
      set_layout({REG_W{1'b1}}, {REG_W{1'b1}}, {REG_W{1'b1}},
                 {REG_W{1'b1}}, {REG_W{1'b1}}, {REG_W{1'b1}});
      add_request(1'b1, 32'hFFFF_FFFE);
      add_request(1'b0, 32'h0);
      add_request(1'b0, 32'h0);
      push_requests();
      wait_for_results(20000);

      // unit source sizes: the outermost index wraps within its width
      set_layout(pack_dims(1, 1, 1, 1), {REG_W{1'b1}}, pack_strides(5, 9),
                 pack_strides(17, 26'h3FF_FFFF), pack_strides(3, 100), pack_strides(7, 11));
      add_request(1'b1, 32'd8190);
      add_request(1'b0, 32'h0);
      add_request(1'b0, 32'h0);
      add_request(1'b1, 32'hFFFF_FFFF);
      add_request(1'b0, 32'h0);
      push_requests();
      wait_for_results(20000);

      // a zero source size pins the source tuple at zero
      set_layout(pack_dims(4, 0, 3, 2), pack_dims(4, 6, 1, 1), pack_strides(8, 64),
                 pack_strides(256, 1024), pack_strides(2, 8), pack_strides(48, 48));
      add_request(1'b1, 32'd5);
      add_request(1'b0, 32'h0);
      push_requests();
      wait_for_results(20000);

      // a zero destination size makes the element count zero
      write_csr(REG_DST_DIMS, pack_dims(3, 3, 0, 3));
      add_request(1'b1, 32'd2);
      add_request(1'b0, 32'h0);
      push_requests();
      wait_for_results(20000);

      // random layouts, each followed by a set of walks
      for (phase = 0; phase < 9; phase++) begin
         pick_layout();
         queue_walks(145, walk_sb.dest_element_count());
         if (phase == 2) long_hold_armed = 1'b1;
         push_requests();
         wait_for_results(20000);
      end

      repeat (250) @(posedge clock);
      walk_sb.report_leftovers();
      if (walk_sb.failures == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

endmodule
